@@ design/edge_center_snap_core_macros.svh @@
// Assertion macros for the edge center snap core.
`ifndef EDGE_CENTER_SNAP_CORE_MACROS_SVH
`define EDGE_CENTER_SNAP_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ECS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge_center_snap_core: same-cycle check failed");
`define ECS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge_center_snap_core: next-cycle check failed");
`else
`define ECS_ASSERT_IMP(label, ante, cons)
`define ECS_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ design/ecs_pkg.sv @@
// Shared types and constants of the edge center snap core.
package ecs_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 2;
  localparam int DEPTH_W        = 16;
  localparam int REQ_W          = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_REACH   = CFG_IDX_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_MOVING = 2'd1,
    REQ_OTHER  = 2'd2,
    REQ_FINISH = 2'd3
  } req_type_t;

endpackage

@@ design/ecs_if.sv @@
// Request and result channel interfaces of the edge center snap core.
interface ecs_in_if #(parameter int COORD_BITS = ecs_pkg::COORD_BITS_DEF);
  import ecs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic signed [COORD_BITS-1:0] corner_x;
  logic signed [COORD_BITS-1:0] corner_y;
  logic signed [COORD_BITS-1:0] offset_x;
  logic signed [COORD_BITS-1:0] offset_y;
  logic [DEPTH_W-1:0]           outline_depth;
  logic                         last_corner;

  modport source (
    output valid, req_type, corner_x, corner_y, offset_x, offset_y, outline_depth,
           last_corner,
    input  ready
  );
  modport sink (
    input  valid, req_type, corner_x, corner_y, offset_x, offset_y, outline_depth,
           last_corner,
    output ready
  );
endinterface

interface ecs_out_if #(parameter int COORD_BITS = ecs_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] new_offset_x;
  logic signed [COORD_BITS+1:0] new_offset_y;
  logic                         guide_x_valid;
  logic signed [COORD_BITS+1:0] guide_x_at;
  logic                         guide_y_valid;
  logic signed [COORD_BITS+1:0] guide_y_at;

  modport source (
    output valid, new_offset_x, new_offset_y, guide_x_valid, guide_x_at, guide_y_valid,
           guide_y_at,
    input  ready
  );
  modport sink (
    input  valid, new_offset_x, new_offset_y, guide_x_valid, guide_x_at, guide_y_valid,
           guide_y_at,
    output ready
  );
endinterface

@@ design/edge_center_snap_core.sv @@
// Top level of the edge center snap core: a six-stage snap pipeline behind an input register.
// One request is accepted every cycle unless the input stalls; a finish request's result is
// loaded into the output register from the last stage.
// The input stalls only while a finish request sits in the last stage and the previous result
// has not been taken.
// Synchronous active-low reset clears the configuration, the drag state and the best matches.
`include "edge_center_snap_core_macros.svh"

module edge_center_snap_core #(
  parameter int COORD_BITS = ecs_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecs_pkg::CFG_W-1:0]      cfg_data,
  ecs_in_if.sink                         in_ch,
  ecs_out_if.source                      out_ch
);
  import ecs_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int OW = CW + 2;
  // Stage targets reach twice the widest configuration value plus a sign bit.
  localparam int TW = CFG_W + 3;
  localparam int LW = (CW + 2 > TW) ? CW + 2 : TW;
  localparam int DW = LW + 1;
  localparam int SW = LW + 2;

  typedef enum logic [2:0] {
    K_NONE,
    K_BEGIN,
    K_CLOSE_MOV,
    K_CLOSE_OTH,
    K_FINISH
  } kind_t;

  function automatic logic signed [LW-1:0] sx(input logic signed [CW-1:0] v);
    return {{(LW-CW){v[CW-1]}}, v};
  endfunction

  // Earliest smallest distance among three candidates; an invalid candidate wins only if none is valid.
  function automatic logic [1:0] pick3(input logic [2:0] ok, input logic [LW-1:0] d0,
                                       input logic [LW-1:0] d1, input logic [LW-1:0] d2);
    logic w01;
    logic w02;
    logic w12;
    w01 = ok[0] && (!ok[1] || d0 <= d1);
    w02 = ok[0] && (!ok[2] || d0 <= d2);
    w12 = ok[1] && (!ok[2] || d1 <= d2);
    if (w01 && w02) return 2'd0;
    else if (!w01 && w12) return 2'd1;
    else return 2'd2;
  endfunction

  logic adv;

  // Configuration registers.
  logic [CFG_W-1:0] stage_w_r;
  logic [CFG_W-1:0] stage_h_r;
  logic [CFG_W-1:0] reach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_w_r <= '0;
      stage_h_r <= '0;
      reach_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STAGE_WIDTH:  stage_w_r <= cfg_data;
        CFG_STAGE_HEIGHT: stage_h_r <= cfg_data;
        CFG_SNAP_REACH:   reach_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                  p0_valid_r;
  req_type_t             p0_req_r;
  logic signed [CW-1:0]  p0_c_r [2];
  logic signed [CW-1:0]  p0_o_r [2];
  logic [DEPTH_W-1:0]    p0_depth_r;
  logic                  p0_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (adv) begin
      p0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_req_r   <= req_type_t'(in_ch.req_type);
      p0_c_r[0]  <= in_ch.corner_x;
      p0_c_r[1]  <= in_ch.corner_y;
      p0_o_r[0]  <= in_ch.offset_x;
      p0_o_r[1]  <= in_ch.offset_y;
      p0_depth_r <= in_ch.outline_depth;
      p0_last_r  <= in_ch.last_corner;
    end
  end

  // Stage A: corner min/max accumulator, drag offset and moving depth.
  logic signed [CW-1:0] run_min_r [2];
  logic signed [CW-1:0] run_max_r [2];
  logic signed [CW-1:0] run_min_nxt [2];
  logic signed [CW-1:0] run_max_nxt [2];
  logic signed [CW-1:0] drag_r [2];
  logic signed [CW-1:0] drag_nxt [2];
  logic [DEPTH_W-1:0]   mdepth_r;
  logic [DEPTH_W-1:0]   mdepth_nxt;
  logic                 first_r;
  logic                 first_nxt;
  kind_t                a_kind;

  always_comb begin
    run_min_nxt = run_min_r;
    run_max_nxt = run_max_r;
    drag_nxt    = drag_r;
    mdepth_nxt  = mdepth_r;
    first_nxt   = first_r;
    a_kind      = K_NONE;
    if (p0_valid_r) begin
      case (p0_req_r)
        REQ_BEGIN: begin
          drag_nxt   = p0_o_r;
          mdepth_nxt = p0_depth_r;
          first_nxt  = 1'b1;
          a_kind     = K_BEGIN;
        end
        REQ_MOVING, REQ_OTHER: begin
          for (int a = 0; a < 2; a++) begin
            if (first_r) begin
              run_min_nxt[a] = p0_c_r[a];
              run_max_nxt[a] = p0_c_r[a];
            end else begin
              if (p0_c_r[a] < run_min_r[a]) run_min_nxt[a] = p0_c_r[a];
              if (p0_c_r[a] > run_max_r[a]) run_max_nxt[a] = p0_c_r[a];
            end
          end
          first_nxt = p0_last_r;
          if (p0_last_r) begin
            if (p0_req_r == REQ_MOVING) a_kind = K_CLOSE_MOV;
            else if (p0_depth_r != mdepth_r) a_kind = K_CLOSE_OTH;
          end
        end
        REQ_FINISH: a_kind = K_FINISH;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= '{default: '0};
      run_max_r <= '{default: '0};
      drag_r    <= '{default: '0};
      mdepth_r  <= '0;
      first_r   <= 1'b1;
    end else if (adv) begin
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
      drag_r    <= drag_nxt;
      mdepth_r  <= mdepth_nxt;
      first_r   <= first_nxt;
    end
  end

  kind_t                p1_kind_r;
  logic signed [CW-1:0] p1_min_r [2];
  logic signed [CW-1:0] p1_max_r [2];
  logic signed [CW-1:0] p1_off_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_min_r <= run_min_nxt;
      p1_max_r <= run_max_nxt;
      p1_off_r <= drag_nxt;
    end
  end

  // Stage B: line positions; owns the moving lines.
  logic signed [LW-1:0] mline_r [2][3];
  logic signed [LW-1:0] mline_nxt [2][3];
  logic signed [LW-1:0] b_tgt [2][3];
  logic signed [LW-1:0] b_mov [2][3];
  logic signed [LW-1:0] b_s2 [2];
  logic signed [LW-1:0] b_lo [2];
  logic signed [LW-1:0] b_mid [2];
  logic signed [LW-1:0] b_hi [2];
  logic signed [LW-1:0] b_st [2];

  always_comb begin
    mline_nxt = mline_r;
    b_st[0]   = {{(LW-CFG_W){1'b0}}, stage_w_r};
    b_st[1]   = {{(LW-CFG_W){1'b0}}, stage_h_r};
    for (int a = 0; a < 2; a++) begin
      b_s2[a]     = sx(p1_off_r[a]) <<< 1;
      b_lo[a]     = sx(p1_min_r[a]) <<< 1;
      b_mid[a]    = sx(p1_min_r[a]) + sx(p1_max_r[a]);
      b_hi[a]     = sx(p1_max_r[a]) <<< 1;
      b_mov[a]    = mline_r[a];
      b_tgt[a][0] = b_lo[a];
      b_tgt[a][1] = b_mid[a];
      b_tgt[a][2] = b_hi[a];
    end
    case (p1_kind_r)
      K_BEGIN: mline_nxt = '{default: '0};
      K_CLOSE_MOV: begin
        for (int a = 0; a < 2; a++) begin
          b_mov[a][0]  = b_lo[a] + b_s2[a];
          b_mov[a][1]  = b_mid[a] + b_s2[a];
          b_mov[a][2]  = b_hi[a] + b_s2[a];
          b_tgt[a][0]  = '0;
          b_tgt[a][1]  = b_st[a];
          b_tgt[a][2]  = b_st[a] <<< 1;
          mline_nxt[a] = b_mov[a];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mline_r <= '{default: '0};
    end else if (adv) begin
      mline_r <= mline_nxt;
    end
  end

  kind_t                p2_kind_r;
  logic signed [LW-1:0] p2_tgt_r [2][3];
  logic signed [LW-1:0] p2_mov_r [2][3];
  logic signed [CW-1:0] p2_off_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_tgt_r <= b_tgt;
      p2_mov_r <= b_mov;
      p2_off_r <= p1_off_r;
    end
  end

  // Stage C: signed difference and distance of every target and moving line pair.
  // Pairs are numbered target-major, which is the order ties are resolved in.
  logic signed [DW-1:0] c_delta [2][9];
  logic signed [DW-1:0] c_neg [2][9];
  logic [LW-1:0]        c_dist [2][9];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int g = 0; g < 3; g++) begin
        for (int m = 0; m < 3; m++) begin
          c_delta[a][g*3+m] = {p2_tgt_r[a][g][LW-1], p2_tgt_r[a][g]}
                            - {p2_mov_r[a][m][LW-1], p2_mov_r[a][m]};
          c_neg[a][g*3+m]   = {p2_mov_r[a][m][LW-1], p2_mov_r[a][m]}
                            - {p2_tgt_r[a][g][LW-1], p2_tgt_r[a][g]};
          c_dist[a][g*3+m]  = c_delta[a][g*3+m][DW-1] ? c_neg[a][g*3+m][LW-1:0]
                                                      : c_delta[a][g*3+m][LW-1:0];
        end
      end
    end
  end

  kind_t                p3_kind_r;
  logic signed [LW-1:0] p3_tgt_r [2][3];
  logic [LW-1:0]        p3_dist_r [2][9];
  logic signed [DW-1:0] p3_delta_r [2][9];
  logic signed [CW-1:0] p3_off_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_tgt_r   <= p2_tgt_r;
      p3_dist_r  <= c_dist;
      p3_delta_r <= c_delta;
      p3_off_r   <= p2_off_r;
    end
  end

  // Stage D: reach test and best moving line for each target.
  logic [LW-1:0]        reach2;
  logic [8:0]           d_ok [2];
  logic [1:0]           d_sel [2][3];
  logic                 d_gok [2][3];
  logic [LW-1:0]        d_gdist [2][3];
  logic signed [DW-1:0] d_gdelta [2][3];

  assign reach2 = {{(LW-CFG_W-1){1'b0}}, reach_r, 1'b0};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 9; k++) begin
        d_ok[a][k] = p3_dist_r[a][k] <= reach2;
      end
      for (int g = 0; g < 3; g++) begin
        d_sel[a][g] = pick3(d_ok[a][g*3 +: 3], p3_dist_r[a][g*3], p3_dist_r[a][g*3+1],
                            p3_dist_r[a][g*3+2]);
        d_gok[a][g] = (d_sel[a][g] == 2'd0) ? d_ok[a][g*3] :
                      (d_sel[a][g] == 2'd1) ? d_ok[a][g*3+1] : d_ok[a][g*3+2];
        d_gdist[a][g] = (d_sel[a][g] == 2'd0) ? p3_dist_r[a][g*3] :
                        (d_sel[a][g] == 2'd1) ? p3_dist_r[a][g*3+1] : p3_dist_r[a][g*3+2];
        d_gdelta[a][g] = (d_sel[a][g] == 2'd0) ? p3_delta_r[a][g*3] :
                         (d_sel[a][g] == 2'd1) ? p3_delta_r[a][g*3+1] : p3_delta_r[a][g*3+2];
      end
    end
  end

  kind_t                p4_kind_r;
  logic signed [LW-1:0] p4_tgt_r [2][3];
  logic [2:0]           p4_gok_r [2];
  logic [LW-1:0]        p4_gdist_r [2][3];
  logic signed [DW-1:0] p4_gdelta_r [2][3];
  logic signed [CW-1:0] p4_off_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_tgt_r    <= p3_tgt_r;
      p4_gdist_r  <= d_gdist;
      p4_gdelta_r <= d_gdelta;
      p4_off_r    <= p3_off_r;
      for (int a = 0; a < 2; a++) begin
        p4_gok_r[a] <= {d_gok[a][2], d_gok[a][1], d_gok[a][0]};
      end
    end
  end

  // Stage E: best pair of the outline over its three targets.
  logic [1:0]           e_sel [2];
  logic                 e_ok [2];
  logic [LW-1:0]        e_dist [2];
  logic signed [DW-1:0] e_delta [2];
  logic signed [LW-1:0] e_tgt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      e_sel[a]   = pick3(p4_gok_r[a], p4_gdist_r[a][0], p4_gdist_r[a][1], p4_gdist_r[a][2]);
      e_ok[a]    = (e_sel[a] == 2'd0) ? p4_gok_r[a][0] :
                   (e_sel[a] == 2'd1) ? p4_gok_r[a][1] : p4_gok_r[a][2];
      e_dist[a]  = (e_sel[a] == 2'd0) ? p4_gdist_r[a][0] :
                   (e_sel[a] == 2'd1) ? p4_gdist_r[a][1] : p4_gdist_r[a][2];
      e_delta[a] = (e_sel[a] == 2'd0) ? p4_gdelta_r[a][0] :
                   (e_sel[a] == 2'd1) ? p4_gdelta_r[a][1] : p4_gdelta_r[a][2];
      e_tgt[a]   = (e_sel[a] == 2'd0) ? p4_tgt_r[a][0] :
                   (e_sel[a] == 2'd1) ? p4_tgt_r[a][1] : p4_tgt_r[a][2];
    end
  end

  kind_t                p5_kind_r;
  logic                 p5_ok_r [2];
  logic [LW-1:0]        p5_dist_r [2];
  logic signed [DW-1:0] p5_delta_r [2];
  logic signed [LW-1:0] p5_tgt_r [2];
  logic signed [CW-1:0] p5_off_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_ok_r    <= e_ok;
      p5_dist_r  <= e_dist;
      p5_delta_r <= e_delta;
      p5_tgt_r   <= e_tgt;
      p5_off_r   <= p4_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_kind_r <= K_NONE;
      p2_kind_r <= K_NONE;
      p3_kind_r <= K_NONE;
      p4_kind_r <= K_NONE;
      p5_kind_r <= K_NONE;
    end else if (adv) begin
      p1_kind_r <= a_kind;
      p2_kind_r <= p1_kind_r;
      p3_kind_r <= p2_kind_r;
      p4_kind_r <= p3_kind_r;
      p5_kind_r <= p4_kind_r;
    end
  end

  // Stage F: merge into the best match per axis and form the result of a finish request.
  logic                 bvalid_r [2];
  logic                 bvalid_nxt [2];
  logic [LW-1:0]        bdist_r [2];
  logic [LW-1:0]        bdist_nxt [2];
  logic signed [DW-1:0] bdelta_r [2];
  logic signed [DW-1:0] bdelta_nxt [2];
  logic signed [LW-1:0] btgt_r [2];
  logic signed [LW-1:0] btgt_nxt [2];
  logic signed [SW-1:0] f_sum [2];
  logic signed [SW-1:0] f_corr [2];

  always_comb begin
    bvalid_nxt = bvalid_r;
    bdist_nxt  = bdist_r;
    bdelta_nxt = bdelta_r;
    btgt_nxt   = btgt_r;
    for (int a = 0; a < 2; a++) begin
      case (p5_kind_r)
        K_BEGIN: bvalid_nxt[a] = 1'b0;
        K_CLOSE_MOV: begin
          bvalid_nxt[a] = p5_ok_r[a];
          bdist_nxt[a]  = p5_dist_r[a];
          bdelta_nxt[a] = p5_delta_r[a];
          btgt_nxt[a]   = p5_tgt_r[a];
        end
        K_CLOSE_OTH: begin
          if (p5_ok_r[a] && (!bvalid_r[a] || p5_dist_r[a] < bdist_r[a])) begin
            bvalid_nxt[a] = 1'b1;
            bdist_nxt[a]  = p5_dist_r[a];
            bdelta_nxt[a] = p5_delta_r[a];
            btgt_nxt[a]   = p5_tgt_r[a];
          end
        end
        default: ;
      endcase
      f_corr[a] = bvalid_r[a] ? {{(SW-DW){bdelta_r[a][DW-1]}}, bdelta_r[a]} : '0;
      f_sum[a]  = ({{(SW-CW){p5_off_r[a][CW-1]}}, p5_off_r[a]} <<< 1) + f_corr[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '{default: 1'b0};
    end else if (adv) begin
      bvalid_r <= bvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bdist_r  <= bdist_nxt;
      bdelta_r <= bdelta_nxt;
      btgt_r   <= btgt_nxt;
    end
  end

  // Output register.
  logic                 out_valid_r;
  logic signed [OW-1:0] out_off_r [2];
  logic                 out_gv_r [2];
  logic signed [OW-1:0] out_ga_r [2];
  logic                 f_load;

  assign adv    = !((p5_kind_r == K_FINISH) && out_valid_r && !out_ch.ready);
  assign f_load = adv && (p5_kind_r == K_FINISH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (f_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      for (int a = 0; a < 2; a++) begin
        out_off_r[a] <= f_sum[a][OW-1:0];
        out_gv_r[a]  <= bvalid_r[a];
        out_ga_r[a]  <= bvalid_r[a] ? btgt_r[a][OW-1:0] : '0;
      end
    end
  end

  assign in_ch.ready          = adv;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_offset_x  = out_off_r[0];
  assign out_ch.new_offset_y  = out_off_r[1];
  assign out_ch.guide_x_valid = out_gv_r[0];
  assign out_ch.guide_x_at    = out_ga_r[0];
  assign out_ch.guide_y_valid = out_gv_r[1];
  assign out_ch.guide_y_at    = out_ga_r[1];

  `ECS_ASSERT_IMP(a_stall_cause, !in_ch.ready, out_valid_r && !out_ch.ready && (p5_kind_r == K_FINISH))
  `ECS_ASSERT_NXT(a_begin_clears, adv && (p5_kind_r == K_BEGIN), !bvalid_r[0] && !bvalid_r[1])
  `ECS_ASSERT_NXT(a_begin_rearms, adv && p0_valid_r && (p0_req_r == REQ_BEGIN), first_r)
  `ECS_ASSERT_IMP(a_guide_x_zero, out_valid_r && !out_gv_r[0], out_ga_r[0] == '0)

endmodule
